### design/wsdr_pkg.sv
package wsdr_pkg;

	localparam int LIMB_COUNT = 8;
	localparam int LIMB_BITS  = 16;
	localparam int W          = LIMB_BITS * LIMB_COUNT;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_ZERO = 2'd1,
		ST_NEG  = 2'd2
	} status_t;

	// control that travels with each word down the pipe
	typedef struct packed {
		logic    valid;
		logic    neg;
		status_t status;
	} ctl_t;

endpackage

### design/wsdr_step.sv
module wsdr_step (
	input  logic                    clk,
	input  logic                    arst_n,
	input  wsdr_pkg::ctl_t          ctl_in,
	input  logic [wsdr_pkg::W-1:0]  rem_in,
	input  logic [wsdr_pkg::W-1:0]  quo_in,
	input  logic [wsdr_pkg::W-1:0]  dvs_in,
	output wsdr_pkg::ctl_t          ctl_out,
	output logic [wsdr_pkg::W-1:0]  rem_out,
	output logic [wsdr_pkg::W-1:0]  quo_out,
	output logic [wsdr_pkg::W-1:0]  dvs_out
);

	logic [wsdr_pkg::W-1:0] shifted;
	logic [wsdr_pkg::W:0]   diff;
	wsdr_pkg::ctl_t         ctl_s1;
	logic [wsdr_pkg::W-1:0] rem_s1;
	logic [wsdr_pkg::W-1:0] quo_s1;
	logic [wsdr_pkg::W-1:0] dvs_s1;

	// bring in next dividend bit, trial subtract
	assign shifted = {rem_in[wsdr_pkg::W-2:0], quo_in[wsdr_pkg::W-1]};
	assign diff    = {1'b0, shifted} - {1'b0, dvs_in};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		dvs_s1 <= dvs_in;
		if (!diff[wsdr_pkg::W]) begin
			rem_s1 <= diff[wsdr_pkg::W-1:0];
			quo_s1 <= {quo_in[wsdr_pkg::W-2:0], 1'b1};
		end else begin
			rem_s1 <= shifted;
			quo_s1 <= {quo_in[wsdr_pkg::W-2:0], 1'b0};
		end
	end

	assign ctl_out = ctl_s1;
	assign rem_out = rem_s1;
	assign quo_out = quo_s1;
	assign dvs_out = dvs_s1;

endmodule

### design/wide_signed_divide_remainder.sv
// channel  | handshake         | payload
// ---------+-------------------+-----------------------------------------------
// command  | start / busy      | dividend_high, dividend_low, divisor_high/low
// result   | done (one cycle)  | quotient_high/low, remainder_high/low, status
//
// one word may be issued every cycle; busy is always low
// the pipe has an entry stage, one restoring
// step stage per quotient bit, and a sign fix-up stage
// arst_n clears every valid bit; payload registers are not reset
// the receiver cannot stall, so the pipe never holds
module wide_signed_divide_remainder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [63:0] dividend_high,
	input  logic        [63:0] dividend_low,
	input  logic signed [63:0] divisor_high,
	input  logic        [63:0] divisor_low,
	output logic               done,
	output logic signed [63:0] quotient_high,
	output logic        [63:0] quotient_low,
	output logic signed [63:0] remainder_high,
	output logic        [63:0] remainder_low,
	output logic        [1:0]  status
);

	localparam int W = wsdr_pkg::W;

	logic [127:0]   a_full;
	logic [127:0]   b_full;
	logic [W-1:0]   a_w;
	logic [W-1:0]   b_w;
	wsdr_pkg::ctl_t ctl_in;

	wsdr_pkg::ctl_t ctl_s1;
	logic [W-1:0]   mag_s1;
	logic [W-1:0]   div_s1;

	wsdr_pkg::ctl_t ctl_p [0:W];
	logic [W-1:0]   rem_p [0:W];
	logic [W-1:0]   quo_p [0:W];
	logic [W-1:0]   dvs_p [0:W];

	logic [W-1:0]   quo_fix;
	logic [W-1:0]   rem_fix;
	logic           done_q;
	logic [W-1:0]   quo_q;
	logic [W-1:0]   rem_q;
	wsdr_pkg::status_t status_q;

	assign busy = 1'b0;

	// only the low W bits of each operand count
	assign a_full = {dividend_high, dividend_low};
	assign b_full = {divisor_high, divisor_low};
	assign a_w    = a_full[W-1:0];
	assign b_w    = b_full[W-1:0];

	always_comb begin
		ctl_in.valid  = start;
		ctl_in.neg    = a_w[W-1];
		if (b_w == '0) begin
			ctl_in.status = wsdr_pkg::ST_ZERO;
		end else if (b_w[W-1]) begin
			ctl_in.status = wsdr_pkg::ST_NEG;
		end else begin
			ctl_in.status = wsdr_pkg::ST_OK;
		end
	end

	// entry stage: magnitude of dividend (most negative stays as unsigned 2^(W-1))
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		mag_s1 <= a_w[W-1] ? (~a_w + 1'b1) : a_w;
		div_s1 <= b_w;
	end

	assign ctl_p[0] = ctl_s1;
	assign rem_p[0] = '0;
	assign quo_p[0] = mag_s1;
	assign dvs_p[0] = div_s1;

	// one restoring step per stage, dividend bits shift out msb first
	for (genvar k = 0; k < W; k++) begin : g_step
		wsdr_step u_step (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl_in  (ctl_p[k]),
			.rem_in  (rem_p[k]),
			.quo_in  (quo_p[k]),
			.dvs_in  (dvs_p[k]),
			.ctl_out (ctl_p[k+1]),
			.rem_out (rem_p[k+1]),
			.quo_out (quo_p[k+1]),
			.dvs_out (dvs_p[k+1])
		);
	end

	// sign fix-up: negate both for a negative dividend, zero on error
	always_comb begin
		if (ctl_p[W].status != wsdr_pkg::ST_OK) begin
			quo_fix = '0;
			rem_fix = '0;
		end else if (ctl_p[W].neg) begin
			quo_fix = ~quo_p[W] + 1'b1;
			rem_fix = ~rem_p[W] + 1'b1;
		end else begin
			quo_fix = quo_p[W];
			rem_fix = rem_p[W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl_p[W].valid;
		end
	end

	always_ff @(posedge clk) begin
		quo_q    <= quo_fix;
		rem_q    <= rem_fix;
		status_q <= ctl_p[W].status;
	end

	// high halves sign-extended from bit W-1
	assign done           = done_q;
	assign quotient_high  = 64'($signed(quo_q[W-1:64]));
	assign quotient_low   = quo_q[63:0];
	assign remainder_high = 64'($signed(rem_q[W-1:64]));
	assign remainder_low  = rem_q[63:0];
	assign status         = status_q;

	// an error word carries zero results
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status_q != wsdr_pkg::ST_OK |-> quo_q == '0 && rem_q == '0)
		else $error("error word with nonzero result");

	// a negative-divisor flag only for a divisor with its sign bit set
	a_neg_flag: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s1.valid && ctl_s1.status == wsdr_pkg::ST_NEG |-> div_s1[W-1])
		else $error("negative divisor flag without sign bit");

	// remainder below divisor in magnitude after the last step
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_p[W].valid && ctl_p[W].status == wsdr_pkg::ST_OK |-> rem_p[W] < dvs_p[W])
		else $error("partial remainder not below divisor");

endmodule
